[rtl/path_string_hash32_assert.svh]
// Assertion macros for the path string hash block.
`ifndef PATH_STRING_HASH32_ASSERT_SVH
`define PATH_STRING_HASH32_ASSERT_SVH

// Implication checked at every rising edge of clk, off while arst_n is low.
`define PHS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, same clock and reset as above.
`define PHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/phs_pkg.sv]
// Shared types, constants and the character normalizer of the path string hash.
package phs_pkg;

	localparam logic [31:0] KEY_RESET   = 32'hF4FA8928;
	localparam logic [31:0] ACCA_RESET  = 32'h37A8470E;
	localparam logic [31:0] ACCB_RESET  = 32'h7758B42B;
	localparam logic [31:0] TAIL_WORD_0 = 32'h9BE74448;
	localparam logic [31:0] TAIL_WORD_1 = 32'h66F42C48;
	localparam logic [31:0] KEY_XOR     = 32'h267B0B11;
	localparam logic [31:0] A_OR        = 32'h02040801;
	localparam logic [31:0] A_AND       = 32'hBFEF7FDF;
	localparam logic [31:0] B_OR        = 32'h00804021;
	localparam logic [31:0] B_AND       = 32'h7DFEFBFF;

	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW    = $clog2(CMD_DEPTH);

	// One queued command: mix a word, end the string, or both (word first).
	typedef struct packed {
		logic        mix;
		logic [31:0] word;
		logic        last;
		logic        empty;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] normalize(input logic [7:0] c);
		logic [7:0] r;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end else if (c == CH_BSLASH) begin
			r = CH_SLASH;
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage

[rtl/path_string_hash32.sv]
// Path string hash: top level joining front end, command queue and mixing back end.
//
// Input stream: one path character per transaction. s_tdata carries the byte,
// s_tuser marks it as a real character (low for a bare end marker), s_tlast
// ends the string. Characters are lower-cased, backslash becomes slash, and
// only the first BUFFER_BYTES-1 characters of a string are hashed.
// Output stream: one 32-bit hash per string on m_tdata (0 for an empty string).
// Throughput: one character per cycle while the four-entry command queue has
// room; each completed word then passes the back end through queue pop, key/mask
// prep, two 32x32 multiplies and carry fold in turn.
// From the last transaction to m_tvalid: an empty string goes straight to the
// result state; otherwise any partial word and the two trailer words each pass
// prep, multiply and fold, after any words still queued.
// Reset clears the packer, the queue and the key/accumulators to their start
// values and drops m_tvalid. A stall on m_tready holds the result register;
// the back end then waits and the queue fills until s_tready drops.
module path_string_hash32 #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] has_char
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] hash_value
);

	`include "path_string_hash32_assert.svh"

	logic                fire;
	logic                push;
	logic                pop;
	phs_pkg::cmd_t       cmd_in;
	phs_pkg::cmd_t       cmd_out;
	phs_pkg::fifo_stat_t fstat;

	assign s_tready = !fstat.full;
	assign fire     = s_tvalid && s_tready;

	phs_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (s_tdata),
		.has_char  (s_tuser),
		.last_char (s_tlast),
		.push      (push),
		.cmd       (cmd_in)
	);

	phs_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_in),
		.pop     (pop),
		.cmd_out (cmd_out),
		.stat    (fstat)
	);

	phs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_avail (!fstat.empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	`PHS_ASSERT_IMP(a_no_overflow, push, !fstat.full, "command pushed into full queue")
	`PHS_ASSERT_IMP(a_no_underflow, pop, !fstat.empty, "command popped from empty queue")
	`PHS_ASSERT_NEXT(a_pop_empties, pop && !push && !fstat.full, !fstat.full,
		"queue full right after a pop")

endmodule

[rtl/phs_front.sv]
// Front end: normalizes characters, packs words and issues mix and end commands.
module phs_front #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          char_code,
	input  logic                has_char,
	input  logic                last_char,
	output logic                push,
	output phs_pkg::cmd_t       cmd
);

	localparam int CW = $clog2(BUFFER_BYTES);

	logic [23:0]   wa_q;
	logic [1:0]    lane_q;
	logic [CW-1:0] count_q;

	logic [7:0]    ch;
	logic          take;
	logic          wrap;
	logic [23:0]   wa_ins;
	logic [23:0]   wa_next;
	logic [1:0]    lane_next;
	logic [CW-1:0] count_next;

	always_comb begin
		ch         = phs_pkg::normalize(char_code);
		take       = has_char && (count_q < CW'(BUFFER_BYTES - 1));
		wrap       = take && (lane_q == 2'd3);
		wa_ins     = wa_q | (24'(ch) << {lane_q, 3'b000});
		wa_next    = wrap ? 24'd0 : (take ? wa_ins : wa_q);
		lane_next  = wrap ? 2'd0 : (take ? lane_q + 2'd1 : lane_q);
		count_next = take ? count_q + CW'(1) : count_q;

		push       = fire && (wrap || last_char);
		cmd.mix    = wrap || (last_char && (lane_next != 2'd0));
		cmd.word   = wrap ? {ch, wa_q} : {8'd0, wa_next};
		cmd.last   = last_char;
		cmd.empty  = (count_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q    <= '0;
			lane_q  <= '0;
			count_q <= '0;
		end else if (fire) begin
			// a string end returns the packer to its start
			if (last_char) begin
				wa_q    <= '0;
				lane_q  <= '0;
				count_q <= '0;
			end else begin
				wa_q    <= wa_next;
				lane_q  <= lane_next;
				count_q <= count_next;
			end
		end
	end

endmodule

[rtl/phs_cmd_fifo.sv]
// Short command queue between the front end and the mixing back end.
module phs_cmd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  phs_pkg::cmd_t        cmd_in,
	input  logic                 pop,
	output phs_pkg::cmd_t        cmd_out,
	output phs_pkg::fifo_stat_t  stat
);

	localparam int AW = phs_pkg::CMD_AW;

	phs_pkg::cmd_t mem [phs_pkg::CMD_DEPTH];

	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	always_comb begin
		stat.full  = (count_q == (AW + 1)'(phs_pkg::CMD_DEPTH));
		stat.empty = (count_q == '0);
		cmd_out    = mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (AW + 1)'(1);
				2'b01:   count_q <= count_q - (AW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/phs_back.sv]
// Back end: word mixing sequencer with masked multiplies and the result register.
module phs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  phs_pkg::cmd_t       cmd,
	input  logic                cmd_avail,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_FOLD,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		PH_WORD,
		PH_TAIL0,
		PH_TAIL1
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic [31:0] key_q;
	logic [31:0] acc_a_q;
	logic [31:0] acc_b_q;
	logic [31:0] word_q;
	logic        last_q;
	logic        empty_q;
	logic [31:0] ax_q;
	logic [31:0] bx_q;
	logic [31:0] ma_q;
	logic [31:0] mb_q;
	logic [63:0] prod_a_q;
	logic [63:0] prod_b_q;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	logic [31:0] key_n;
	logic [31:0] salt;
	logic [31:0] ax;
	logic [31:0] bx;
	logic [31:0] lo1_a;
	logic [32:0] sum_a;
	logic [31:0] na;
	logic [31:0] lo1_b;
	logic [31:0] dbl_b;
	logic [32:0] sum_b;
	logic [31:0] nb;

	assign pop      = (state_q == ST_IDLE) && cmd_avail;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		key_n = {key_q[30:0], key_q[31]};
		salt  = phs_pkg::KEY_XOR ^ key_n;
		ax    = acc_a_q ^ word_q;
		bx    = acc_b_q ^ word_q;

		// fold the high half back in with end-around carry
		lo1_a = prod_a_q[31:0] + {31'd0, |prod_a_q[63:32]};
		sum_a = {1'b0, lo1_a} + {1'b0, prod_a_q[63:32]};
		na    = sum_a[31:0] + {31'd0, sum_a[32]};

		// second fold doubles the high half; the carry is worth two
		lo1_b = prod_b_q[31:0] + {31'd0, prod_b_q[63]};
		dbl_b = {prod_b_q[62:32], 1'b0};
		sum_b = {1'b0, lo1_b} + {1'b0, dbl_b};
		nb    = sum_b[31:0] + {30'd0, sum_b[32], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_WORD;
			key_q      <= phs_pkg::KEY_RESET;
			acc_a_q    <= phs_pkg::ACCA_RESET;
			acc_b_q    <= phs_pkg::ACCB_RESET;
			word_q     <= '0;
			last_q     <= 1'b0;
			empty_q    <= 1'b0;
			ax_q       <= '0;
			bx_q       <= '0;
			ma_q       <= '0;
			mb_q       <= '0;
			prod_a_q   <= '0;
			prod_b_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// the result state drives the valid flag itself
			if (m_tready && (state_q != ST_RESULT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_avail) begin
						last_q  <= cmd.last;
						empty_q <= cmd.empty;
						if (cmd.mix) begin
							word_q  <= cmd.word;
							phase_q <= PH_WORD;
							state_q <= ST_PREP;
						end else if (cmd.empty) begin
							state_q <= ST_RESULT;
						end else begin
							word_q  <= phs_pkg::TAIL_WORD_0;
							phase_q <= PH_TAIL0;
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					key_q   <= key_n;
					ax_q    <= ax;
					bx_q    <= bx;
					ma_q    <= ((salt + bx) | phs_pkg::A_OR) & phs_pkg::A_AND;
					mb_q    <= ((salt + ax) | phs_pkg::B_OR) & phs_pkg::B_AND;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_a_q <= {32'd0, ma_q} * {32'd0, ax_q};
					prod_b_q <= {32'd0, bx_q} * {32'd0, mb_q};
					state_q  <= ST_FOLD;
				end
				ST_FOLD: begin
					acc_a_q <= na;
					acc_b_q <= nb;
					unique case (phase_q)
						PH_WORD: begin
							if (last_q) begin
								word_q  <= phs_pkg::TAIL_WORD_0;
								phase_q <= PH_TAIL0;
								state_q <= ST_PREP;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						PH_TAIL0: begin
							word_q  <= phs_pkg::TAIL_WORD_1;
							phase_q <= PH_TAIL1;
							state_q <= ST_PREP;
						end
						PH_TAIL1: begin
							state_q <= ST_RESULT;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= empty_q ? 32'd0 : (acc_a_q ^ acc_b_q);
						key_q      <= phs_pkg::KEY_RESET;
						acc_a_q    <= phs_pkg::ACCA_RESET;
						acc_b_q    <= phs_pkg::ACCB_RESET;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sim/path_string_hash32_tb.sv]
// Self-checking testbench for the path string hash block: directed and random paths.
module path_string_hash32_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_BYTES = 256;
	localparam int ITEM_TARGET  = 1800;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int GAP_MAX      = 14;

	// Tracks the hash state of the string in flight and the hashes still owed by the block.
	class path_hash_board;
		bit [31:0] key_r;
		bit [31:0] sum_a;
		bit [31:0] sum_b;
		bit [31:0] pend;
		bit [1:0]  lane;
		int        kept;
		int        keep_max;
		bit        dropped;
		bit [31:0] exp_hashes[$];
		int        errors;
		int        n_strings;
		int        n_empty;
		int        n_cut;
		int        n_chars;
		int        n_checked;

		function new(int keep_limit);
			keep_max = keep_limit;
			restart();
		endfunction

		function void restart();
			key_r   = phs_pkg::KEY_RESET;
			sum_a   = phs_pkg::ACCA_RESET;
			sum_b   = phs_pkg::ACCB_RESET;
			pend    = 32'd0;
			lane    = 2'd0;
			kept    = 0;
			dropped = 1'b0;
		endfunction

		function bit [7:0] fold_case(bit [7:0] c);
			if (c >= phs_pkg::CH_UPPER_A && c <= phs_pkg::CH_UPPER_Z) begin
				return c + phs_pkg::CASE_OFFSET;
			end else if (c == phs_pkg::CH_BSLASH) begin
				return phs_pkg::CH_SLASH;
			end
			return c;
		endfunction

		// One word into key and accumulators; both products fold their high half back in.
		function void stir_word(bit [31:0] w);
			bit [31:0] salt, ma, mb, lo, hi, dbl, na, nb;
			bit [63:0] prod;
			bit [32:0] tot;
			key_r = {key_r[30:0], key_r[31]};
			salt  = phs_pkg::KEY_XOR ^ key_r;
			sum_a = sum_a ^ w;
			sum_b = sum_b ^ w;

			ma   = ((salt + sum_b) | phs_pkg::A_OR) & phs_pkg::A_AND;
			prod = {32'd0, ma} * {32'd0, sum_a};
			lo   = prod[31:0];
			hi   = prod[63:32];
			if (hi != 32'd0) begin
				lo = lo + 32'd1;
			end
			tot = {1'b0, lo} + {1'b0, hi};
			na  = tot[31:0];
			if (tot[32]) begin
				na = na + 32'd1;
			end

			// second mask uses sum_a after the xor but before its update
			mb   = ((salt + sum_a) | phs_pkg::B_OR) & phs_pkg::B_AND;
			prod = {32'd0, sum_b} * {32'd0, mb};
			lo   = prod[31:0];
			hi   = prod[63:32];
			dbl  = {hi[30:0], 1'b0};
			if (hi[31]) begin
				lo = lo + 32'd1;
			end
			tot = {1'b0, lo} + {1'b0, dbl};
			nb  = tot[31:0];
			if (tot[32]) begin
				nb = nb + 32'd2;
			end

			sum_a = na;
			sum_b = nb;
		endfunction

		function void take_char(bit [7:0] c, bit has, bit is_end);
			bit [7:0]  n;
			bit [31:0] h;
			if (has) begin
				n_chars++;
				if (kept < keep_max) begin
					n = fold_case(c);
					if (lane == 2'd3) begin
						stir_word(pend | {n, 24'd0});
						pend = 32'd0;
						lane = 2'd0;
					end else begin
						pend = pend | ({24'd0, n} << (8 * lane));
						lane = lane + 2'd1;
					end
					kept++;
				end else begin
					dropped = 1'b1;
				end
			end
			if (is_end) begin
				if (kept == 0) begin
					h = 32'd0;
					n_empty++;
				end else begin
					if (lane != 2'd0) begin
						stir_word(pend);
					end
					stir_word(phs_pkg::TAIL_WORD_0);
					stir_word(phs_pkg::TAIL_WORD_1);
					h = sum_a ^ sum_b;
				end
				if (dropped) begin
					n_cut++;
				end
				n_strings++;
				exp_hashes.push_back(h);
				restart();
			end
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_hash(bit [31:0] got);
			bit [31:0] want;
			if (exp_hashes.size() == 0) begin
				report_mismatch($sformatf("hash %08h arrived with none pending", got));
			end else begin
				want = exp_hashes.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("hash %0d: got %08h, want %08h",
						n_checked, got, want));
				end
				n_checked++;
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	path_hash_board board = new(BUFFER_BYTES - 1);

	bit hold_rx      = 1'b0;
	bit pressure_arm = 1'b0;
	bit tx_calm      = 1'b0;
	bit rx_calm      = 1'b0;
	int rx_wait      = 0;
	int items_sent   = 0;
	int cycle_count  = 0;

	path_string_hash32 #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d hashes pending", cycle_count,
				board.exp_hashes.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: check each transaction, then draw the stall before the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				board.check_hash(m_tdata);
				if ($urandom_range(0, 19) == 0) begin
					rx_calm = !rx_calm;
				end
				rx_wait = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (hold_rx) begin
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off while characters keep coming, so the queue backs up.
	initial begin
		wait (pressure_arm);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	function automatic bit [7:0] pick_char();
		bit [7:0] c;
		case ($urandom_range(0, 5))
			0: c = 8'($urandom_range(8'h41, 8'h5A));
			1: c = 8'($urandom_range(8'h61, 8'h7A));
			2: begin
				case ($urandom_range(0, 2))
					0: c = phs_pkg::CH_BSLASH;
					1: c = phs_pkg::CH_SLASH;
					default: c = 8'h2E;
				endcase
			end
			3: c = 8'($urandom_range(8'h30, 8'h39));
			4: begin
				// neighbors of the ranges that get rewritten, plus the byte extremes
				case ($urandom_range(0, 5))
					0: c = 8'h40;
					1: c = 8'h5B;
					2: c = 8'h5D;
					3: c = 8'h00;
					4: c = 8'hFF;
					default: c = 8'h7B;
				endcase
			end
			default: c = 8'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	// Call just after a rising edge; returns just after the edge that accepts the transaction.
	task automatic send_item(input logic [7:0] c, input logic has, input logic is_end);
		int gap;
		gap = (tx_calm || hold_rx) ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= has;
		s_tlast  <= is_end;
		do begin
			@(posedge clk);
		end while (!s_tready);
		board.take_char(c, has, is_end);
		if (has || is_end) begin
			items_sent++;
		end
	endtask

	initial begin
		int len;
		int str_idx;
		bit tail_char;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string, then an item with neither flag
		send_item(8'h41, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b0);
		// single character that also ends the string
		send_item(8'h41, 1'b1, 1'b1);
		// exactly one full word, end on the fourth character
		send_item(8'h5A, 1'b1, 1'b0);
		send_item(phs_pkg::CH_BSLASH, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		// range edges around the case fold, closed by a bare end marker
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h40, 1'b1, 1'b0);
		send_item(8'h5B, 1'b1, 1'b0);
		send_item(8'h60, 1'b1, 1'b0);
		send_item(8'h7B, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		// idle item inside a string
		send_item(phs_pkg::CH_SLASH, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h42, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// two characters, then three
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b1);
		send_item(8'h2E, 1'b1, 1'b0);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'h39, 1'b1, 1'b1);

		pressure_arm = 1'b1;
		str_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			if (str_idx == 5) begin
				len = BUFFER_BYTES - 2;
			end else if (str_idx == 30) begin
				len = BUFFER_BYTES - 1;
			end else if (str_idx == 55) begin
				len = BUFFER_BYTES + $urandom_range(0, 44);
			end else if ($urandom_range(0, 9) == 0) begin
				len = 0;
			end else begin
				len = $urandom_range(1, 24);
			end
			tail_char = ($urandom_range(0, 2) != 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 24) == 0) begin
					send_item(8'($urandom), 1'b0, 1'b0);
				end
				send_item(pick_char(), 1'b1, (i == len - 1) && tail_char);
			end
			if (len == 0 || !tail_char) begin
				send_item(8'($urandom), 1'b0, 1'b1);
			end
			str_idx++;
		end
		s_tvalid <= 1'b0;

		while (board.exp_hashes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d paths (%0d empty, %0d cut at %0d chars) from %0d characters.",
			board.n_strings, board.n_empty, board.n_cut, BUFFER_BYTES - 1, board.n_chars);
		$display("Checked %0d hashes, %0d mismatches; receiver held off %0d cycles once.",
			board.n_checked, board.errors, HOLD_CYCLES);
		if (board.errors == 0 && board.exp_hashes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
